// ===== hw/rtl/gnig_pkg.sv =====
// Package for the grid neighbourhood index generator.
// Types, sizes, register codes and the small helper functions used by the top level.
// No dependencies.
package gnig_pkg;

    localparam int IDX_W          = 24;
    localparam int SIZE_W         = 9;
    localparam int MAX_AXIS_NODES = 256;
    localparam int AREA_W         = 17;
    localparam int TOTAL_W        = 25;
    localparam int ADDR_W         = 5;
    localparam int DIV1_STEPS     = 24;
    localparam int DIV2_STEPS     = 17;
    localparam int DIV_STAGES     = DIV1_STEPS + DIV2_STEPS;
    localparam int PIPE_DEPTH     = DIV_STAGES + 4;
    localparam int N_COMB         = 27;

    typedef enum logic [2:0] {
        REG_DIMS         = 3'd0,
        REG_NODES_ACROSS = 3'd1,
        REG_NODES_UP     = 3'd2,
        REG_NODES_DEEP   = 3'd3,
        REG_WRAP_X       = 3'd4,
        REG_WRAP_Y       = 3'd5,
        REG_WRAP_Z       = 3'd6
    } reg_idx_t;

    localparam logic [1:0] DIMS_3D = 2'd3;

    typedef struct packed {
        logic              func;
        logic              bad;
        logic [IDX_W-1:0]  num;
        logic [SIZE_W-1:0] rem;
        logic [IDX_W-1:0]  quo;
        logic [SIZE_W-1:0] x;
    } div_t;

    typedef struct packed {
        logic              func;
        logic              bad;
        logic [SIZE_W-1:0] x;
        logic [SIZE_W-1:0] y;
        logic [SIZE_W-1:0] z;
        logic [AREA_W-1:0] cy0;
        logic [IDX_W-1:0]  cz0;
    } prod_t;

    typedef struct packed {
        logic              vld;
        logic [SIZE_W-1:0] coord;
        logic [IDX_W-1:0]  contrib;
    } ent_t;

    typedef ent_t [2:0] ent3_t;

    typedef struct packed {
        logic             vld;
        logic             zb;   // reachable with no step on this axis
        logic             nb;   // reachable with a step on this axis
        logic [IDX_W-1:0] contrib;
    } slot_t;

    typedef slot_t [2:0] slot3_t;

    typedef struct packed {
        logic   func;
        logic   bad;
        slot3_t xs;
        slot3_t ys;
        slot3_t zs;
    } sort_t;

    typedef struct packed {
        logic [N_COMB-1:0]     mask;
        logic [2:0][IDX_W-1:0] xc;
        logic [2:0][IDX_W-1:0] yc;
        logic [2:0][IDX_W-1:0] zc;
    } emit_t;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [SIZE_W:0] div_step(logic [SIZE_W-1:0] rem, logic b,
                                                 logic [SIZE_W-1:0] d);
        logic [SIZE_W:0] r2;
        logic [SIZE_W:0] df;
        r2 = {rem, b};
        df = r2 - {1'b0, d};
        if (r2 >= {1'b0, d})
            return {1'b1, df[SIZE_W-1:0]};
        else
            return {1'b0, r2[SIZE_W-1:0]};
    endfunction

    // distinct coordinates of one axis in ascending order, with step flags
    function automatic slot3_t axis_sort(ent3_t e);
        logic [2:0]      uniq;
        logic [2:0][1:0] rank;
        slot3_t          s;
        s    = '0;
        uniq = '0;
        rank = '0;
        for (int a = 0; a < 3; a++) begin
            uniq[a] = e[a].vld;
            for (int b = 0; b < a; b++)
                if (e[b].vld && e[b].coord == e[a].coord)
                    uniq[a] = 1'b0;
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                if (uniq[b] && e[b].coord < e[a].coord)
                    rank[a] = rank[a] + 2'd1;
        for (int a = 0; a < 3; a++) begin
            if (uniq[a]) begin
                s[rank[a]].vld     = 1'b1;
                s[rank[a]].contrib = e[a].contrib;
                s[rank[a]].zb      = e[1].vld && e[1].coord == e[a].coord;
                s[rank[a]].nb      = (e[0].vld && e[0].coord == e[a].coord) ||
                                     (e[2].vld && e[2].coord == e[a].coord);
            end
        end
        return s;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] n);
        return (n > SIZE_W'(MAX_AXIS_NODES)) ? SIZE_W'(MAX_AXIS_NODES) : n;
    endfunction

endpackage

// ===== hw/rtl/grid_neighbourhood_index_generator.sv =====
// Top level of the grid neighbourhood index generator.
// Config registers, divider pipeline, neighbour sort stages and result emitter.
// Depends on gnig_pkg.
//
// Usage: program the grid through the APB port while idle (dims, three axis
// sizes, three wrap flags at byte addresses 0,4,...,24). Each transfer on the
// s_axis side carries a linear node index (tdata) and the neighbourhood kind
// (tuser: 0 Moore, 1 von Neumann). For it the m_axis side gives the distinct
// neighbour indices in ascending order, one per transfer, tlast on the final
// one, tuser=1 on each. A bad index or a node without neighbours gives a
// single transfer with tuser=0, tdata=0, tlast=1.
// Path: the input transfer loads the first of 47 registers (45 pipeline
// registers, then the emitter and the output register), and m_axis is
// driven from the output register. The coordinate split is a 41-stage
// one-bit-per-stage divider. Throughput: one item enters per cycle while the
// emitter keeps up; the emitter sends one result per cycle while m_axis is
// ready, so an item holds the emitter until its last result is sent.
// s_axis_tready is low after each register write while the node count settles.
// Reset clears registers to a 2-D 1x1 grid, no wrap, pipeline empty.
// When m_axis stalls, the output register holds; the pipeline then stalls
// once its last stage holds an item and s_axis_tready drops, nothing is lost.
module grid_neighbourhood_index_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gnig_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,   // node_number
    input  logic                         s_axis_tuser,   // func
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata,   // neighbour_index
    output logic                         m_axis_tuser,   // found
    output logic                         m_axis_tlast    // last
);
    import gnig_pkg::*;

    localparam int ST_B = DIV_STAGES + 1;
    localparam int ST_C = DIV_STAGES + 2;
    localparam int ST_D = DIV_STAGES + 3;

    logic [1:0]        dims_reg;
    logic [SIZE_W-1:0] nodes_across_reg;
    logic [SIZE_W-1:0] nodes_up_reg;
    logic [SIZE_W-1:0] nodes_deep_reg;
    logic              wrap_x_reg;
    logic              wrap_y_reg;
    logic              wrap_z_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [1:0]         cfg_settle_reg;

    logic              three_d;
    logic [SIZE_W-1:0] na_c;
    logic [SIZE_W-1:0] nu_c;
    logic [SIZE_W-1:0] nd_c;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign three_d = (dims_reg == DIMS_3D);
    assign na_c    = clamp_size(nodes_across_reg);
    assign nu_c    = clamp_size(nodes_up_reg);
    assign nd_c    = three_d ? clamp_size(nodes_deep_reg) : SIZE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg         <= 2'd2;
            nodes_across_reg <= SIZE_W'(1);
            nodes_up_reg     <= SIZE_W'(1);
            nodes_deep_reg   <= SIZE_W'(1);
            wrap_x_reg       <= 1'b0;
            wrap_y_reg       <= 1'b0;
            wrap_z_reg       <= 1'b0;
            area_reg         <= AREA_W'(1);
            total_reg        <= TOTAL_W'(1);
            cfg_settle_reg   <= '0;
        end
        else
        begin
            area_reg       <= AREA_W'(na_c) * AREA_W'(nu_c);
            total_reg      <= TOTAL_W'(area_reg) * TOTAL_W'(nd_c);
            cfg_settle_reg <= {cfg_settle_reg[0], cfg_wr};
            if (cfg_wr)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_DIMS:         dims_reg         <= pwdata[1:0];
                    REG_NODES_ACROSS: nodes_across_reg <= pwdata[SIZE_W-1:0];
                    REG_NODES_UP:     nodes_up_reg     <= pwdata[SIZE_W-1:0];
                    REG_NODES_DEEP:   nodes_deep_reg   <= pwdata[SIZE_W-1:0];
                    REG_WRAP_X:       wrap_x_reg       <= pwdata[0];
                    REG_WRAP_Y:       wrap_y_reg       <= pwdata[0];
                    REG_WRAP_Z:       wrap_z_reg       <= pwdata[0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_DIMS:         prdata = {30'd0, dims_reg};
            REG_NODES_ACROSS: prdata = {23'd0, nodes_across_reg};
            REG_NODES_UP:     prdata = {23'd0, nodes_up_reg};
            REG_NODES_DEEP:   prdata = {23'd0, nodes_deep_reg};
            REG_WRAP_X:       prdata = {31'd0, wrap_x_reg};
            REG_WRAP_Y:       prdata = {31'd0, wrap_y_reg};
            REG_WRAP_Z:       prdata = {31'd0, wrap_z_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // pipeline control: every stage moves together
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  en;
    logic                  em_load;
    logic                  em_issue;
    logic                  em_last;
    logic                  out_load;

    assign en            = !vld_reg[ST_D] || em_load;
    assign s_axis_tready = en && (cfg_settle_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid && s_axis_tready};
    end

    // x = idx mod na, q = idx / na, then y = q mod nu, z = q / nu
    div_t dv_reg  [0:DIV_STAGES];
    div_t dv_next [1:DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_div
            div_t          nxt;
            logic [SIZE_W:0] st;
            if (k < DIV1_STEPS)
            begin : g_first
                assign st = div_step(dv_reg[k].rem, dv_reg[k].num[DIV1_STEPS-1-k], na_c);
                always_comb
                begin
                    nxt     = dv_reg[k];
                    nxt.rem = st[SIZE_W-1:0];
                    nxt.quo = {dv_reg[k].quo[IDX_W-2:0], st[SIZE_W]};
                end
            end
            else if (k == DIV1_STEPS)
            begin : g_swap
                assign st = div_step('0, dv_reg[k].quo[DIV2_STEPS-1], nu_c);
                always_comb
                begin
                    nxt     = dv_reg[k];
                    nxt.x   = dv_reg[k].rem;
                    nxt.num = dv_reg[k].quo;
                    nxt.rem = st[SIZE_W-1:0];
                    nxt.quo = {{(IDX_W-1){1'b0}}, st[SIZE_W]};
                end
            end
            else
            begin : g_second
                assign st = div_step(dv_reg[k].rem, dv_reg[k].num[DIV_STAGES-1-k], nu_c);
                always_comb
                begin
                    nxt     = dv_reg[k];
                    nxt.rem = st[SIZE_W-1:0];
                    nxt.quo = {dv_reg[k].quo[IDX_W-2:0], st[SIZE_W]};
                end
            end
            assign dv_next[k+1] = nxt;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].func <= s_axis_tuser;
            dv_reg[0].bad  <= ({1'b0, s_axis_tdata} >= total_reg);
            dv_reg[0].num  <= s_axis_tdata;
            dv_reg[0].rem  <= '0;
            dv_reg[0].quo  <= '0;
            dv_reg[0].x    <= '0;
            for (int i = 1; i <= DIV_STAGES; i++)
                dv_reg[i] <= dv_next[i];
        end
    end

    // products for the y and z contributions
    prod_t b_reg;
    prod_t b_next;
    always_comb
    begin
        b_next.func = dv_reg[DIV_STAGES].func;
        b_next.bad  = dv_reg[DIV_STAGES].bad;
        b_next.x    = dv_reg[DIV_STAGES].x;
        b_next.y    = dv_reg[DIV_STAGES].rem;
        b_next.z    = dv_reg[DIV_STAGES].quo[SIZE_W-1:0];
        b_next.cy0  = AREA_W'(dv_reg[DIV_STAGES].rem) * AREA_W'(na_c);
        b_next.cz0  = IDX_W'(dv_reg[DIV_STAGES].quo[SIZE_W-1:0]) * IDX_W'(area_reg);
    end

    // per-axis candidates, sorted and merged
    sort_t c_reg;
    sort_t c_next;
    ent3_t xe;
    ent3_t ye;
    ent3_t ze;
    logic  x_top;
    logic  y_top;
    logic  z_top;
    always_comb
    begin
        x_top = ({1'b0, b_reg.x} + 10'd1) >= {1'b0, na_c};
        y_top = ({1'b0, b_reg.y} + 10'd1) >= {1'b0, nu_c};
        z_top = ({1'b0, b_reg.z} + 10'd1) >= {1'b0, nd_c};

        xe[0].vld     = (b_reg.x != '0) || wrap_x_reg;
        xe[0].coord   = (b_reg.x != '0) ? b_reg.x - SIZE_W'(1) : na_c - SIZE_W'(1);
        xe[0].contrib = IDX_W'(xe[0].coord);
        xe[1].vld     = 1'b1;
        xe[1].coord   = b_reg.x;
        xe[1].contrib = IDX_W'(b_reg.x);
        xe[2].vld     = !x_top || wrap_x_reg;
        xe[2].coord   = x_top ? '0 : b_reg.x + SIZE_W'(1);
        xe[2].contrib = IDX_W'(xe[2].coord);

        ye[0].vld     = (b_reg.y != '0) || wrap_y_reg;
        ye[0].coord   = (b_reg.y != '0) ? b_reg.y - SIZE_W'(1) : nu_c - SIZE_W'(1);
        ye[0].contrib = (b_reg.y != '0) ? IDX_W'(AREA_W'(b_reg.cy0 - AREA_W'(na_c)))
                                        : IDX_W'(AREA_W'(area_reg - AREA_W'(na_c)));
        ye[1].vld     = 1'b1;
        ye[1].coord   = b_reg.y;
        ye[1].contrib = IDX_W'(b_reg.cy0);
        ye[2].vld     = !y_top || wrap_y_reg;
        ye[2].coord   = y_top ? '0 : b_reg.y + SIZE_W'(1);
        ye[2].contrib = y_top ? '0 : IDX_W'(AREA_W'(b_reg.cy0 + AREA_W'(na_c)));

        ze[0].vld     = three_d && ((b_reg.z != '0) || wrap_z_reg);
        ze[0].coord   = (b_reg.z != '0) ? b_reg.z - SIZE_W'(1) : nd_c - SIZE_W'(1);
        ze[0].contrib = (b_reg.z != '0) ? IDX_W'(b_reg.cz0 - IDX_W'(area_reg))
                                        : IDX_W'(total_reg - TOTAL_W'(area_reg));
        ze[1].vld     = 1'b1;
        ze[1].coord   = b_reg.z;
        ze[1].contrib = b_reg.cz0;
        ze[2].vld     = three_d && (!z_top || wrap_z_reg);
        ze[2].coord   = z_top ? '0 : b_reg.z + SIZE_W'(1);
        ze[2].contrib = z_top ? '0 : IDX_W'(b_reg.cz0 + IDX_W'(area_reg));

        c_next.func = b_reg.func;
        c_next.bad  = b_reg.bad;
        c_next.xs   = axis_sort(xe);
        c_next.ys   = axis_sort(ye);
        c_next.zs   = axis_sort(ze);
    end

    // which (z,y,x) slot combinations are neighbours; bit order is ascending index
    emit_t d_reg;
    emit_t d_next;
    always_comb
    begin
        d_next.mask = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int m = 0; m < 3; m++)
                    d_next.mask[i*9+j*3+m] =
                        !c_reg.bad && c_reg.zs[i].vld && c_reg.ys[j].vld &&
                        c_reg.xs[m].vld &&
                        (c_reg.func ?
                            ((c_reg.zs[i].nb && c_reg.ys[j].zb && c_reg.xs[m].zb) ||
                             (c_reg.zs[i].zb && c_reg.ys[j].nb && c_reg.xs[m].zb) ||
                             (c_reg.zs[i].zb && c_reg.ys[j].zb && c_reg.xs[m].nb)) :
                            (c_reg.zs[i].nb || c_reg.ys[j].nb || c_reg.xs[m].nb));
        for (int i = 0; i < 3; i++)
        begin
            d_next.xc[i] = c_reg.xs[i].contrib;
            d_next.yc[i] = c_reg.ys[i].contrib;
            d_next.zc[i] = c_reg.zs[i].contrib;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

    // emitter: one neighbour per cycle while the output register is free, lowest remaining combination first
    logic              em_valid_reg;
    emit_t             em_reg;
    logic [N_COMB-1:0] em_rest;
    logic [1:0]        si;
    logic [1:0]        sj;
    logic [1:0]        sk;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic              out_found_reg;
    logic              out_last_reg;
    logic [IDX_W-1:0]  out_index_next;

    assign out_load = !out_valid_reg || m_axis_tready;
    assign em_issue = em_valid_reg && out_load;
    assign em_rest  = em_reg.mask & (em_reg.mask - N_COMB'(1));
    assign em_last  = (em_rest == '0);
    assign em_load  = vld_reg[ST_D] && (!em_valid_reg || (em_issue && em_last));

    always_comb
    begin
        si = '0;
        sj = '0;
        sk = '0;
        for (int i = 2; i >= 0; i--)
            for (int j = 2; j >= 0; j--)
                for (int m = 2; m >= 0; m--)
                    if (em_reg.mask[i*9+j*3+m])
                    begin
                        si = 2'(i);
                        sj = 2'(j);
                        sk = 2'(m);
                    end
        out_index_next = (em_reg.mask == '0) ? '0 :
                         em_reg.zc[si] + em_reg.yc[sj] + em_reg.xc[sk];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (em_load)
                em_valid_reg <= 1'b1;
            else if (em_issue && em_last)
                em_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= em_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_load)
            em_reg <= d_reg;
        else if (em_issue)
            em_reg.mask <= em_rest;
        if (em_issue)
        begin
            out_index_reg <= out_index_next;
            out_found_reg <= (em_reg.mask != '0);
            out_last_reg  <= em_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_index_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("result without neighbour not marked last");

    a_input_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transfer missing from first stage");

    a_emitter_loads: assert property (@(posedge clk) disable iff (!rst_n)
        em_load |=> em_valid_reg)
        else $error("emitter dropped a loaded item");

endmodule
